// ----- rtl/assert_macros.svh -----
// Assertion macros for the tween engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LCTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define LCTE_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/lcte_pkg.sv -----
// Types, codes and constants shared by the tween engine modules.
package lcte_pkg;

  localparam int unsigned LED_CAP = 64;
  localparam int unsigned PROG_W  = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [1:0] REG_LED_COUNT = 2'd0;
  localparam logic [1:0] REG_PERIOD    = 2'd1;
  localparam logic [1:0] REG_ENABLE    = 2'd2;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_KILL    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_STATUS  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_ANIM  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_DONE    = 2'd1,
    EV_KILLED  = 2'd2,
    EV_INVALID = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CURVE_LINEAR    = 3'd0,
    CURVE_FLASH     = 3'd1,
    CURVE_SQR_IN    = 3'd2,
    CURVE_SQR_OUT   = 3'd3,
    CURVE_SQR_INOUT = 3'd4
  } ease_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_T_RD,
    ST_T_CHK,
    ST_T_DIV,
    ST_T_EASE,
    ST_T_WR,
    ST_C_RD,
    ST_C_WR,
    ST_C_INV
  } top_state_e;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_MUL,
    ES_F,
    ES_CMUL,
    ES_CADD,
    ES_DONE
  } ease_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] elapsed;
    logic [23:0] start_col;
    logic [23:0] end_col;
    logic [15:0] tween;
    logic [15:0] delay;
    logic [2:0]  ease;
    logic [15:0] repeats;
    logic        yoyo;
    logic [1:0]  evt;
    logic [23:0] shown;
  } led_entry_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic [23:0] color;
    logic        cv;
    logic [1:0]  led_state;
    logic [1:0]  evt;
    logic        all_done;
    logic        last;
  } result_t;

endpackage

// ----- rtl/led_color_tween_engine.sv -----
// Top level of the LED color tween engine: command decode, LED walk and result register.
// A command reads its LED in ST_C_RD and registers its result from ST_C_WR (ST_C_INV for an invalid
// index); an unknown command gives no result. The next request is taken only back in ST_IDLE.
// A tick walks all MAX_LEDS entries: each is read, checked and written back, passing through the
// progress divider and the easing unit when it eases; a stalled result holds the walk until taken.
// After reset the LED RAM is cleared entry by entry with the input held not ready.
`include "assert_macros.svh"

module led_color_tween_engine #(
  parameter int unsigned MAX_LEDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] led_index_i,
  input  logic [7:0]  tick_ms_i,
  input  logic [23:0] start_color_i,
  input  logic [23:0] end_color_i,
  input  logic [15:0] tween_ms_i,
  input  logic [15:0] delay_ms_i,
  input  logic [2:0]  ease_kind_i,
  input  logic [15:0] repeat_count_i,
  input  logic        yoyo_i,
  input  logic        from_current_i,
  input  logic        with_delay_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  out_index_o,
  output logic [23:0] pixel_color_o,
  output logic        color_valid_o,
  output logic [1:0]  led_state_o,
  output logic [1:0]  done_event_o,
  output logic        all_done_o,
  output logic        last_o
);
  import lcte_pkg::*;

  localparam int unsigned AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CAP_N = (MAX_LEDS < LED_CAP) ? MAX_LEDS : LED_CAP;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_LEDS - 1);

  top_state_e state_q, state_d;

  logic [6:0]          led_count_q;
  logic [15:0]         period_q;
  logic                enable_q;
  logic [6:0]          act_n;

  logic [AW-1:0]       i_q, i_d;
  logic [15:0]         ft_q, ft_d;
  logic                frame_run_q, frame_run_d;
  logic                flag_q, flag_d;
  logic [MAX_LEDS-1:0] busy_q, busy_d;
  led_entry_t          w_q, w_d;
  logic [23:0]         col_q, col_d;

  logic [2:0]          cmd_q;
  logic [AW-1:0]       idx_q;
  logic [7:0]          tick_q;
  logic [23:0]         start_color_q;
  logic [23:0]         end_color_q;
  logic [15:0]         tween_q;
  logic [15:0]         delay_q;
  logic [2:0]          ease_q;
  logic [15:0]         rep_q;
  logic                yoyo_q;
  logic                from_cur_q;
  logic                with_delay_q;
  logic                req_load;

  logic                out_valid_q;
  result_t             res_q;
  result_t             res;
  logic                emit;
  logic                out_free;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  led_entry_t          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  led_entry_t          ram_rdata;

  logic                div_start;
  logic                div_done;
  logic [15:0]         div_quot;
  logic                ease_start;
  logic                ease_done;
  logic [23:0]         ease_color;

  logic [16:0]         ft_sum;
  logic [15:0]         ft_sat;
  logic [16:0]         el_sum;
  logic [15:0]         el_sat;
  logic                step_i;
  logic                others_busy;
  led_entry_t          nxt;
  logic                fin;

  assign act_n    = (led_count_q > 7'(CAP_N)) ? 7'(CAP_N) : led_count_q;
  assign ft_sum   = {1'b0, ft_q} + 17'(tick_ms_i);
  assign ft_sat   = ft_sum[16] ? 16'hFFFF : ft_sum[15:0];
  assign el_sum   = {1'b0, ram_rdata.elapsed} + 17'(tick_q);
  assign el_sat   = el_sum[16] ? 16'hFFFF : el_sum[15:0];
  assign step_i   = frame_run_q && (16'(i_q) < 16'(act_n));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    others_busy = 1'b0;
    for (int j = 0; j < MAX_LEDS; j++) begin
      if (busy_q[j] && (j < int'(act_n)) && (AW'(j) != i_q)) begin
        others_busy = 1'b1;
      end
    end
  end

  lcte_ram #(
    .WIDTH($bits(led_entry_t)),
    .DEPTH(MAX_LEDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lcte_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(el_sat),
    .divisor_i (ram_rdata.tween),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  lcte_ease u_ease (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ease_start),
    .kind_i     (w_q.ease),
    .prog_i     (div_quot),
    .start_col_i(w_q.start_col),
    .end_col_i  (w_q.end_col),
    .done_o     (ease_done),
    .color_o    (ease_color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= 7'(LED_CAP);
      period_q    <= 16'd16;
      enable_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LED_COUNT: led_count_q <= cfg_data_i[6:0];
        REG_PERIOD:    period_q <= cfg_data_i;
        REG_ENABLE:    enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      i_q         <= '0;
      ft_q        <= '0;
      frame_run_q <= 1'b0;
      flag_q      <= 1'b0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      ft_q        <= ft_d;
      frame_run_q <= frame_run_d;
      flag_q      <= flag_d;
      busy_q      <= busy_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    col_q <= col_d;
    if (emit) begin
      res_q <= res;
    end
    if (req_load) begin
      cmd_q         <= cmd_i;
      idx_q         <= led_index_i[AW-1:0];
      tick_q        <= tick_ms_i;
      start_color_q <= start_color_i;
      end_color_q   <= end_color_i;
      tween_q       <= tween_ms_i;
      delay_q       <= delay_ms_i;
      ease_q        <= ease_kind_i;
      rep_q         <= repeat_count_i;
      yoyo_q        <= yoyo_i;
      from_cur_q    <= from_current_i;
      with_delay_q  <= with_delay_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    ft_d        = ft_q;
    frame_run_d = frame_run_q;
    flag_d      = flag_q;
    busy_d      = busy_q;
    w_d         = w_q;
    col_d       = col_q;
    req_load    = 1'b0;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = i_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = i_q;
    div_start   = 1'b0;
    ease_start  = 1'b0;
    emit        = 1'b0;
    res         = '0;
    nxt         = w_q;
    fin         = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (i_q == LAST_IDX) begin
          i_d     = '0;
          state_d = ST_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_load = 1'b1;
          if (cmd_i == CMD_TICK) begin
            i_d = '0;
            if (enable_q && ft_sat >= period_q) begin
              ft_d        = '0;
              frame_run_d = 1'b1;
            end else begin
              ft_d        = ft_sat;
              frame_run_d = 1'b0;
            end
            state_d = ST_T_RD;
          end else if (cmd_i > CMD_STATUS) begin
            state_d = ST_IDLE;
          end else if (led_index_i >= 16'(act_n)) begin
            state_d = ST_C_INV;
          end else begin
            state_d = ST_C_RD;
          end
        end
      end
      ST_T_RD: begin
        ram_re  = 1'b1;
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        w_d         = ram_rdata;
        w_d.elapsed = el_sat;
        if (step_i && ram_rdata.mode == MODE_ANIM && el_sat < ram_rdata.tween) begin
          div_start = 1'b1;
          state_d   = ST_T_DIV;
        end else begin
          state_d = ST_T_WR;
        end
      end
      ST_T_DIV: begin
        if (div_done) begin
          ease_start = 1'b1;
          state_d    = ST_T_EASE;
        end
      end
      ST_T_EASE: begin
        if (ease_done) begin
          col_d   = ease_color;
          state_d = ST_T_WR;
        end
      end
      ST_T_WR: begin
        if (w_q.mode == MODE_DELAY) begin
          if (w_q.elapsed >= w_q.delay) begin
            nxt.elapsed = '0;
            nxt.mode    = MODE_ANIM;
          end
        end else if (w_q.mode == MODE_ANIM) begin
          res.cv = 1'b1;
          if (w_q.elapsed >= w_q.tween) begin
            res.color   = w_q.end_col;
            nxt.elapsed = '0;
            if (w_q.repeats != '0) begin
              nxt.repeats = w_q.repeats - 16'd1;
              if (w_q.yoyo) begin
                nxt.start_col = w_q.end_col;
                nxt.end_col   = w_q.start_col;
                if (w_q.ease == CURVE_SQR_IN) begin
                  nxt.ease = CURVE_SQR_OUT;
                end else if (w_q.ease == CURVE_SQR_OUT) begin
                  nxt.ease = CURVE_SQR_IN;
                end
              end
            end else begin
              nxt.start_col = w_q.end_col;
              nxt.evt       = EV_DONE;
              nxt.mode      = MODE_IDLE;
              fin           = 1'b1;
            end
          end else begin
            res.color = col_q;
          end
          nxt.shown = res.color;
        end
        res.idx       = 6'(i_q);
        res.led_state = nxt.mode;
        res.evt       = nxt.evt;
        res.all_done  = (fin && !others_busy) ? 1'b1 : flag_q;
        res.last      = (16'(i_q) == 16'(act_n) - 16'd1);
        if (!step_i || out_free) begin
          ram_we    = 1'b1;
          ram_wdata = step_i ? nxt : w_q;
          if (step_i) begin
            emit = 1'b1;
            if (fin) begin
              busy_d[i_q] = 1'b0;
              flag_d      = res.all_done;
            end
          end
          if (i_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_T_RD;
          end
        end
      end
      ST_C_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = ST_C_WR;
      end
      ST_C_WR: begin
        nxt          = ram_rdata;
        res.idx      = 6'(idx_q);
        res.all_done = flag_q;
        res.last     = 1'b1;
        res.evt      = ram_rdata.evt;
        if (cmd_q == CMD_START) begin
          nxt.start_col = from_cur_q ? ram_rdata.shown : start_color_q;
          nxt.end_col   = end_color_q;
          nxt.tween     = tween_q;
          nxt.delay     = delay_q;
          nxt.ease      = ease_q;
          nxt.repeats   = rep_q;
          nxt.yoyo      = yoyo_q;
          nxt.mode      = (delay_q != '0) ? MODE_DELAY : MODE_ANIM;
          nxt.elapsed   = '0;
        end else if (cmd_q == CMD_KILL) begin
          nxt       = '0;
          nxt.evt   = EV_KILLED;
          nxt.shown = ram_rdata.shown;
          res.evt   = EV_KILLED;
        end else if (cmd_q == CMD_RESTART) begin
          nxt.elapsed = '0;
          nxt.mode    = (ram_rdata.delay != '0 && with_delay_q) ? MODE_DELAY : MODE_ANIM;
          nxt.shown   = ram_rdata.start_col;
          res.color   = ram_rdata.start_col;
          res.cv      = 1'b1;
        end else begin
          nxt.evt = EV_NONE;
        end
        res.led_state = (cmd_q == CMD_STATUS) ? ram_rdata.mode : nxt.mode;
        if (out_free) begin
          emit      = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = nxt;
          busy_d[idx_q] = (nxt.mode != MODE_IDLE);
          if (cmd_q == CMD_START || cmd_q == CMD_STATUS) begin
            flag_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_C_INV: begin
        res.evt      = EV_INVALID;
        res.all_done = flag_q;
        res.last     = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = res_q.idx;
  assign pixel_color_o = res_q.color;
  assign color_valid_o = res_q.cv;
  assign led_state_o   = res_q.led_state;
  assign done_event_o  = res_q.evt;
  assign all_done_o    = res_q.all_done;
  assign last_o        = res_q.last;

  `LCTE_ASSERT_NEVER(a_no_overwrite, emit && !out_free, "Result overwrites a pending result.")
  `LCTE_ASSERT(a_div_awaited, div_done |-> (state_q == ST_T_DIV), "Divider finished unawaited.")
  `LCTE_ASSERT(a_ease_awaited, ease_done |-> (state_q == ST_T_EASE), "Easing finished unawaited.")
  `LCTE_ASSERT(a_flag_from_frame, $rose(flag_q) |-> $past(state_q == ST_T_WR), "Flag set outside frame.")

endmodule

// ----- rtl/lcte_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lcte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lcte_div.sv -----
// Restoring divider that forms the Q0.16 tween progress one bit per cycle.
module lcte_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);
  import lcte_pkg::*;

  localparam int unsigned CW = $clog2(PROG_W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   rem_q;
  logic [15:0]   quot_q;
  logic [15:0]   dsr_q;
  logic [16:0]   trial;
  logic          fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(PROG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
      quot_q <= {quot_q[14:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/lcte_ease.sv -----
// Easing unit: turns a progress value and two colors into the blended color.
module lcte_ease (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  kind_i,
  input  logic [15:0] prog_i,
  input  logic [23:0] start_col_i,
  input  logic [23:0] end_col_i,
  output logic        done_o,
  output logic [23:0] color_o
);
  import lcte_pkg::*;

  ease_state_e state_q, state_d;

  logic [2:0]         kind_q;
  logic [15:0]        p_q;
  logic [23:0]        s_q;
  logic [23:0]        e_q;
  logic [23:0]        color_q;
  logic [34:0]        prod_q;
  logic [32:0]        f_q;
  logic signed [41:0] cprod_q;
  logic [1:0]         ch_q;

  logic [15:0]        u;
  logic [16:0]        mul_a;
  logic [17:0]        mul_b;
  logic [34:0]        prod;
  logic [34:0]        f_calc;
  logic [7:0]         s_ch;
  logic [7:0]         e_ch;
  logic signed [8:0]  diff;
  logic signed [41:0] cprod_d;
  logic signed [41:0] num;
  logic               direct;

  assign u      = {p_q[14:0], 1'b0};
  assign direct = (kind_i == CURVE_FLASH) || (kind_i > CURVE_SQR_INOUT);

  always_comb begin
    if (kind_q == CURVE_SQR_OUT) begin
      mul_a = 17'(p_q);
      mul_b = 18'h20000 - 18'(p_q);
    end else if (kind_q == CURVE_SQR_INOUT && p_q[15]) begin
      mul_a = 17'(u);
      mul_b = 18'(u);
    end else begin
      mul_a = 17'(p_q);
      mul_b = 18'(p_q);
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    if (kind_q == CURVE_LINEAR) begin
      f_calc = 35'({p_q, 17'b0});
    end else if (kind_q == CURVE_SQR_INOUT) begin
      if (p_q[15]) begin
        f_calc = {3'b001, 32'b0} + 35'({u, 17'b0}) - prod_q;
      end else begin
        f_calc = {prod_q[32:0], 2'b0};
      end
    end else begin
      f_calc = {prod_q[33:0], 1'b0};
    end
  end

  always_comb begin
    unique case (ch_q)
      2'd0: begin
        s_ch = s_q[7:0];
        e_ch = e_q[7:0];
      end
      2'd1: begin
        s_ch = s_q[15:8];
        e_ch = e_q[15:8];
      end
      default: begin
        s_ch = s_q[23:16];
        e_ch = e_q[23:16];
      end
    endcase
  end

  assign diff    = $signed({1'b0, e_ch}) - $signed({1'b0, s_ch});
  assign cprod_d = diff * $signed({9'b0, f_q});
  assign num     = $signed({1'b0, s_ch, 33'b0}) + cprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ES_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ES_IDLE: begin
        if (start_i) begin
          state_d = direct ? ES_DONE : ES_MUL;
        end
      end
      ES_MUL:  state_d = ES_F;
      ES_F:    state_d = ES_CMUL;
      ES_CMUL: state_d = ES_CADD;
      ES_CADD: state_d = (ch_q == 2'd2) ? ES_DONE : ES_CMUL;
      ES_DONE: state_d = ES_IDLE;
      default: state_d = ES_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ES_IDLE: begin
        if (start_i) begin
          kind_q <= kind_i;
          p_q    <= prog_i;
          s_q    <= start_col_i;
          e_q    <= end_col_i;
          ch_q   <= 2'd0;
          if (kind_i == CURVE_FLASH) begin
            color_q <= prog_i[15] ? end_col_i : start_col_i;
          end else begin
            color_q <= '0;
          end
        end
      end
      ES_MUL:  prod_q <= prod;
      ES_F:    f_q <= f_calc[32:0];
      ES_CMUL: cprod_q <= cprod_d;
      ES_CADD: begin
        unique case (ch_q)
          2'd0:    color_q[7:0]   <= num[40:33];
          2'd1:    color_q[15:8]  <= num[40:33];
          default: color_q[23:16] <= num[40:33];
        endcase
        ch_q <= ch_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign done_o  = (state_q == ES_DONE);
  assign color_o = color_q;

endmodule
